/* design/dtq_pkg.sv */
package dtq_pkg;

  // Default sizes
  localparam int MaxCharsDef   = 9;
  localparam int IntDigitsDef  = 3;
  localparam int FracDigitsDef = 4;
  localparam int FracBitsDef   = 8;

  // Field and state widths
  localparam int CharW   = 8;
  localparam int CountW  = 4;
  localparam int IntCntW = 2;
  localparam int FracCntW = 3;
  localparam int IntValW = 10;
  localparam int FracValW = 14;
  localparam int ErrW    = 3;
  localparam int ValueW  = 16;
  localparam int MagW    = ValueW + 1;

  // Largest magnitudes for a positive and a negative result
  localparam logic [MagW-1:0] MagLimPos = MagW'(32767);
  localparam logic [MagW-1:0] MagLimNeg = MagW'(32768);

  // Characters
  localparam logic [CharW-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;

  // Status codes; a lower nonzero code has priority
  localparam logic [ErrW-1:0] ERR_NONE       = 3'd0;
  localparam logic [ErrW-1:0] ERR_LONG       = 3'd1;
  localparam logic [ErrW-1:0] ERR_INT_LONG   = 3'd2;
  localparam logic [ErrW-1:0] ERR_FRAC_LONG  = 3'd3;
  localparam logic [ErrW-1:0] ERR_INT_DIGIT  = 3'd4;
  localparam logic [ErrW-1:0] ERR_RANGE      = 3'd5;
  localparam logic [ErrW-1:0] ERR_FRAC_DIGIT = 3'd6;

  // Parsed number handed from the character front end to the divider
  typedef struct packed {
    logic                negative;
    logic [IntValW-1:0]  int_value;
    logic [FracValW-1:0] frac_value;
    logic [FracCntW-1:0] frac_digits;
    logic [ErrW-1:0]     error;
  } dtq_num_t;

  function automatic logic [ErrW-1:0] merge_err(logic [ErrW-1:0] cur, logic [ErrW-1:0] code);
    logic [ErrW-1:0] res;
    res = cur;
    if (cur == ERR_NONE || code < cur) res = code;
    return res;
  endfunction

  function automatic logic [FracValW-1:0] pow_ten(logic [FracCntW-1:0] n);
    logic [FracValW-1:0] res;
    case (n)
      3'd0:    res = 14'd1;
      3'd1:    res = 14'd10;
      3'd2:    res = 14'd100;
      3'd3:    res = 14'd1000;
      default: res = 14'd10000;
    endcase
    return res;
  endfunction

endpackage

/* design/dtq_parse.sv */
module dtq_parse import dtq_pkg::*; #(
  parameter int MAX_CHARS   = MaxCharsDef,
  parameter int INT_DIGITS  = IntDigitsDef,
  parameter int FRAC_DIGITS = FracDigitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [CharW-1:0] char_i,
  input  logic             last_i,
  output dtq_num_t         num_o
);

  localparam logic [1:0] PH_SIGN = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;

  logic [1:0]          phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [IntCntW-1:0]  id_q, id_d;
  logic [FracCntW-1:0] fd_q, fd_d;
  logic [IntValW-1:0]  int_q, int_d;
  logic [FracValW-1:0] frac_q, frac_d;
  logic [ErrW-1:0]     err_q, err_d;

  logic                is_digit;
  logic [3:0]          dval;
  logic [1:0]          ph;
  logic                sign_taken;
  logic [13:0]         int_x10;
  logic [17:0]         frac_x10;

  assign is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign dval     = is_digit ? 4'(char_i - CHAR_ZERO) : 4'd0;
  assign int_x10  = {1'b0, int_q, 3'b000} + {3'b000, int_q, 1'b0} + {10'd0, dval};
  assign frac_x10 = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0} + {14'd0, dval};

  always_comb begin
    phase_d    = phase_q;
    neg_d      = neg_q;
    cnt_d      = cnt_q;
    id_d       = id_q;
    fd_d       = fd_q;
    int_d      = int_q;
    frac_d     = frac_q;
    err_d      = err_q;
    ph         = phase_q;
    sign_taken = 1'b0;
    if (take_i) begin
      if (cnt_q >= CountW'(MAX_CHARS)) begin
        err_d = merge_err(err_d, ERR_LONG);
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
      if (ph == PH_SIGN) begin
        ph      = PH_INT;
        phase_d = PH_INT;
        if (char_i == CHAR_PLUS) begin
          sign_taken = 1'b1;
        end else if (char_i == CHAR_MINUS) begin
          neg_d      = 1'b1;
          sign_taken = 1'b1;
        end
      end
      if (!sign_taken) begin
        if (ph == PH_INT) begin
          if (char_i == CHAR_POINT) begin
            phase_d = PH_FRAC;
          end else if (id_q < IntCntW'(INT_DIGITS)) begin
            id_d = id_q + 1'b1;
            if (is_digit) int_d = int_x10[IntValW-1:0];
            else          err_d = merge_err(err_d, ERR_INT_DIGIT);
          end else begin
            err_d = merge_err(err_d, ERR_INT_LONG);
          end
        end else begin
          if (fd_q < FracCntW'(FRAC_DIGITS)) begin
            fd_d = fd_q + 1'b1;
            if (is_digit) frac_d = frac_x10[FracValW-1:0];
            else          err_d  = merge_err(err_d, ERR_FRAC_DIGIT);
          end else begin
            err_d = merge_err(err_d, ERR_FRAC_LONG);
          end
        end
      end
    end
  end

  // Hand over the state as it stands after the final character
  assign num_o = '{negative: neg_d, int_value: int_d, frac_value: frac_d,
                   frac_digits: fd_d, error: err_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIGN;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      id_q    <= '0;
      fd_q    <= '0;
      int_q   <= '0;
      frac_q  <= '0;
      err_q   <= ERR_NONE;
    end else if (take_i && last_i) begin
      // number closed: start over for the next one
      phase_q <= PH_SIGN;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      id_q    <= '0;
      fd_q    <= '0;
      int_q   <= '0;
      frac_q  <= '0;
      err_q   <= ERR_NONE;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
      id_q    <= id_d;
      fd_q    <= fd_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      err_q   <= err_d;
    end
  end

endmodule

/* design/dtq_div.sv */
module dtq_div import dtq_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dtq_num_t          num_i,
  input  logic              out_ready_i,
  output logic              busy_o,
  output logic              out_valid_o,
  output logic [ValueW-1:0] value_o,
  output logic [ErrW-1:0]   status_o
);

  localparam int BitsW = FRAC_BITS + 1;
  localparam int StepW = $clog2(FRAC_BITS + 1);
  localparam logic [ValueW-1:0] IntLimPos = ValueW'(32767 >> FRAC_BITS);
  localparam logic [ValueW-1:0] IntLimNeg = ValueW'(32768 >> FRAC_BITS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]          st_q;
  dtq_num_t            num_q;
  logic [ErrW-1:0]     err_q;
  logic [FracValW-1:0] p_q;
  logic [FracValW-1:0] rem_q;
  logic [BitsW-1:0]    bits_q;
  logic [StepW-1:0]    step_q;
  logic                vld_q;
  logic [ValueW-1:0]   value_q;
  logic [ErrW-1:0]     status_q;

  // Shared subtract unit: twice the remainder minus the divisor
  logic [FracValW+1:0] trial;
  logic                ge;
  logic [ValueW-1:0]   int_lim;
  logic [MagW-1:0]     mag;
  logic [MagW-1:0]     mag_lim;
  logic                fin_go;

  assign trial   = {1'b0, rem_q, 1'b0} - {2'b00, p_q};
  assign ge      = !trial[FracValW+1];
  assign int_lim = num_q.negative ? IntLimNeg : IntLimPos;
  assign mag     = (MagW'(num_q.int_value) << FRAC_BITS) + MagW'(bits_q);
  assign mag_lim = num_q.negative ? MagLimNeg : MagLimPos;

  // Hold the last step until the output register is free
  assign fin_go  = (st_q == ST_FIN) && (!vld_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      vld_q <= 1'b0;
    end else begin
      if (fin_go) begin
        vld_q <= 1'b1;
      end else if (vld_q && out_ready_i) begin
        vld_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE:  if (start_i) st_q <= ST_PREP;
        ST_PREP:  st_q <= ST_DIV;
        ST_DIV:   if (step_q == StepW'(FRAC_BITS - 1)) st_q <= ST_ROUND;
        ST_ROUND: st_q <= ST_FIN;
        ST_FIN:   if (fin_go) st_q <= ST_IDLE;
        default:  st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) num_q <= num_i;
      end
      ST_PREP: begin
        if ({6'd0, num_q.int_value} > int_lim) err_q <= merge_err(num_q.error, ERR_RANGE);
        else                                    err_q <= num_q.error;
        p_q    <= pow_ten(num_q.frac_digits);
        rem_q  <= num_q.frac_value;
        bits_q <= '0;
        step_q <= '0;
      end
      ST_DIV: begin
        // one quotient bit per cycle, restoring
        bits_q <= {bits_q[BitsW-2:0], ge};
        rem_q  <= ge ? trial[FracValW-1:0] : {rem_q[FracValW-2:0], 1'b0};
        step_q <= step_q + 1'b1;
      end
      ST_ROUND: begin
        // round up only above one half
        if (ge && trial != '0) bits_q <= bits_q + 1'b1;
      end
      ST_FIN: begin
        if (fin_go) begin
          if (err_q != ERR_NONE) begin
            value_q  <= '0;
            status_q <= err_q;
          end else if (mag > mag_lim) begin
            value_q  <= '0;
            status_q <= ERR_RANGE;
          end else begin
            value_q  <= num_q.negative ? (ValueW'(0) - mag[ValueW-1:0]) : mag[ValueW-1:0];
            status_q <= ERR_NONE;
          end
        end
      end
      default: ;
    endcase
  end

  assign busy_o      = (st_q != ST_IDLE);
  assign out_valid_o = vld_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

/* design/decimal_text_to_q7_8_top.sv */
// Converts decimal text of the form [+|-]eee.ffff, one character per beat with tlast on
// the final character, to a signed Q7.8 value and a status code (zero value on error).
// A character without tlast does not stall the input. After the tlast character the block
// holds tready low while one shared subtractor forms the fraction bits one per cycle
// by restoring division, rounds, and range-checks the result; the result beat then
// waits in an output register. Characters of the next number are taken while that beat
// waits; the stall after the next tlast character grows longer only while the earlier
// beat is still held at the output.
module decimal_text_to_q7_8_top import dtq_pkg::*; #(
  parameter int MAX_CHARS   = MaxCharsDef,
  parameter int INT_DIGITS  = IntDigitsDef,
  parameter int FRAC_DIGITS = FracDigitsDef,
  parameter int FRAC_BITS   = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] character
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [15:0] value, [18:16] status, [23:19] zero
);

  dtq_num_t          num;
  logic              take;
  logic              busy;
  logic              out_valid;
  logic [ValueW-1:0] value;
  logic [ErrW-1:0]   status;

  assign s_axis_tready_o = !busy;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  dtq_parse #(
    .MAX_CHARS  (MAX_CHARS),
    .INT_DIGITS (INT_DIGITS),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_parse (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .char_i(s_axis_tdata_i),
    .last_i(s_axis_tlast_i),
    .num_o (num)
  );

  dtq_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (take && s_axis_tlast_i),
    .num_i      (num),
    .out_ready_i(m_axis_tready_i),
    .busy_o     (busy),
    .out_valid_o(out_valid),
    .value_o    (value),
    .status_o   (status)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {5'd0, status, value};

endmodule

/* design/dtq_check.sv */
module dtq_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[18:16] != 3'd0) |-> (m_axis_tdata_o[15:0] == 16'd0))
    else $error("nonzero value with error status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[18:16] != 3'd7) && (m_axis_tdata_o[23:19] == 5'd0))
    else $error("bad status or pad bits");

  // The closing character starts the division, which stalls the input
  a_last_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input ready right after closing character");

endmodule

bind decimal_text_to_q7_8_top dtq_check u_check (.*);
